/* rtl/core/dmpq_pkg.sv */
`default_nettype none

package dmpq_pkg;

   localparam int ENTRIES_DEFAULT = 64;

   localparam int WEIGHT_W   = 32;
   localparam int PAYLOAD_W  = 31;
   localparam int DEADLINE_W = 32;
   localparam int TIME_W     = 32;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;

   typedef enum logic {
      OP_INSERT  = 1'b0,
      OP_EXTRACT = 1'b1
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PERMANENT = 2'd0,
      KIND_EXPIRE    = 2'd1,
      KIND_REKEY     = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_FOUND = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic                  valid;
      kind_type              kind;
      logic [WEIGHT_W-1:0]   weight;
      logic [WEIGHT_W-1:0]   later_weight;
      logic [PAYLOAD_W-1:0]  payload;
      logic [DEADLINE_W-1:0] deadline;
      logic [TIME_W-1:0]     sequence_stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

/* rtl/core/dmpq_ram.sv */
`default_nettype none

module dmpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/deadline_min_priority_queue.sv */
// deadline_min_priority_queue
//
// Request channel (req_*): op 0 inserts an entry (kind, weight, payload,
// deadline, later_weight), op 1 extracts the live entry of least current
// weight. Every accepted item is one time step.
// Response channel (rsp_*): an extract always answers with status found or
// empty; an insert answers only when dropped on a full table.
// Each item sweeps the whole table in one RAM, one entry per cycle, through a
// two-stage evaluate pipeline, then commits at most one write. An item holds
// the block from acceptance through a read of every entry, the drain of the
// pipeline and the commit. A response is registered at the commit, and a new
// item is taken only once the block is idle again; the single RAM read port is
// why the sweep reads the entries one at a time.
// A new item is taken while a response still waits. If the receiver stalls
// and the next item needs to respond, it holds in its commit step until the
// output register frees.
// After reset the block runs a clearing pass that zeroes every RAM entry
// with req_ready low; time restarts at zero.

`default_nettype none

module deadline_min_priority_queue #(
   parameter int ENTRIES = dmpq_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_op,
   input  wire logic [dmpq_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [dmpq_pkg::WEIGHT_W-1:0]     req_weight,
   input  wire logic [dmpq_pkg::PAYLOAD_W-1:0]    req_payload,
   input  wire logic [dmpq_pkg::DEADLINE_W-1:0]   req_deadline,
   input  wire logic [dmpq_pkg::WEIGHT_W-1:0]     req_later_weight,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [dmpq_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [dmpq_pkg::PAYLOAD_W-1:0]    rsp_payload_out
);

   import dmpq_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = IDX_W + 1;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0] time_now_ff, time_now_in;

   // current item
   op_type                item_op_ff, item_op_in;
   kind_type              item_kind_ff, item_kind_in;
   logic [WEIGHT_W-1:0]   item_weight_ff, item_weight_in;
   logic [WEIGHT_W-1:0]   item_later_ff, item_later_in;
   logic [PAYLOAD_W-1:0]  item_payload_ff, item_payload_in;
   logic [DEADLINE_W-1:0] item_deadline_ff, item_deadline_in;
   logic [TIME_W-1:0]     item_time_ff, item_time_in;

   // read pipeline
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0] s1_idx_ff, s1_idx_in;
   logic             s1_live_ff, s1_live_in;
   logic [WEIGHT_W-1:0]  s1_key_ff, s1_key_in;
   logic [TIME_W-1:0]    s1_age_ff, s1_age_in;
   logic [PAYLOAD_W-1:0] s1_payload_ff, s1_payload_in;

   // scan results
   logic                 best_found_ff, best_found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [WEIGHT_W-1:0]  best_key_ff, best_key_in;
   logic [TIME_W-1:0]    best_age_ff, best_age_in;
   logic [PAYLOAD_W-1:0] best_payload_ff, best_payload_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type        rd_entry;
   logic             out_free;
   logic             accept;
   logic             past_deadline;

   dmpq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_entry        = entry_type'(rd_data);
   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign req_ready       = (state_ff == ST_IDLE);
   assign accept          = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_payload_out = rsp_payload_ff;
   assign past_deadline   = (item_time_ff >= rd_entry.deadline);

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      time_now_in      = time_now_ff;
      item_op_in       = item_op_ff;
      item_kind_in     = item_kind_ff;
      item_weight_in   = item_weight_ff;
      item_later_in    = item_later_ff;
      item_payload_in  = item_payload_ff;
      item_deadline_in = item_deadline_ff;
      item_time_in     = item_time_ff;
      best_found_in    = best_found_ff;
      best_idx_in      = best_idx_ff;
      best_key_in      = best_key_ff;
      best_age_in      = best_age_ff;
      best_payload_in  = best_payload_ff;
      free_found_in    = free_found_ff;
      free_idx_in      = free_idx_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_payload_in   = rsp_payload_ff;
      wr_en            = 1'b0;
      wr_addr          = cnt_ff[IDX_W-1:0];
      wr_entry         = '0;
      rd_en            = 1'b0;
      rd_addr          = cnt_ff[IDX_W-1:0];
      rd_valid_in      = 1'b0;
      rd_idx_in        = cnt_ff[IDX_W-1:0];

      // stage one: liveness, current key and age of the entry just read
      s1_valid_in   = rd_valid_ff;
      s1_idx_in     = rd_idx_ff;
      s1_live_in    = rd_entry.valid
                      && !(rd_entry.kind == KIND_EXPIRE && past_deadline);
      s1_key_in     = (rd_entry.kind == KIND_REKEY && past_deadline)
                      ? rd_entry.later_weight : rd_entry.weight;
      s1_age_in     = item_time_ff - rd_entry.sequence_stamp;
      s1_payload_in = rd_entry.payload;

      // stage two: running best and first free slot
      if (s1_valid_ff) begin
         if (!free_found_ff && !s1_live_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = s1_idx_ff;
         end
         if (s1_live_ff && (!best_found_ff || s1_key_ff < best_key_ff
               || (s1_key_ff == best_key_ff && s1_age_ff > best_age_ff))) begin
            best_found_in   = 1'b1;
            best_idx_in     = s1_idx_ff;
            best_key_in     = s1_key_ff;
            best_age_in     = s1_age_ff;
            best_payload_in = s1_payload_ff;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ENTRIES - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               item_op_in       = op_type'(req_op);
               item_kind_in     = (req_kind inside {KIND_EXPIRE, KIND_REKEY})
                                  ? kind_type'(req_kind) : KIND_PERMANENT;
               item_weight_in   = req_weight;
               item_later_in    = req_later_weight;
               item_payload_in  = req_payload;
               item_deadline_in = req_deadline;
               item_time_in     = time_now_ff;
               time_now_in      = time_now_ff + 1'b1;
               best_found_in    = 1'b0;
               free_found_in    = 1'b0;
               cnt_in           = '0;
               state_in         = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != CNT_W'(ENTRIES)) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end else if (!rd_valid_ff && !s1_valid_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (item_op_ff == OP_INSERT && free_found_ff) begin
               wr_en                   = 1'b1;
               wr_addr                 = free_idx_ff;
               wr_entry.valid          = 1'b1;
               wr_entry.kind           = item_kind_ff;
               wr_entry.weight         = item_weight_ff;
               wr_entry.later_weight   = item_later_ff;
               wr_entry.payload        = item_payload_ff;
               wr_entry.deadline       = item_deadline_ff;
               wr_entry.sequence_stamp = item_time_ff;
               state_in                = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '0;
               state_in       = ST_IDLE;
               if (item_op_ff == OP_INSERT) begin
                  rsp_status_in = STATUS_FULL;
               end else if (best_found_ff) begin
                  wr_en          = 1'b1;
                  wr_addr        = best_idx_ff;
                  rsp_status_in  = STATUS_FOUND;
                  rsp_payload_in = best_payload_ff;
               end else begin
                  rsp_status_in = STATUS_EMPTY;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         time_now_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         time_now_ff   <= time_now_in;
         rd_valid_ff   <= rd_valid_in;
         s1_valid_ff   <= s1_valid_in;
         best_found_ff <= best_found_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_op_ff       <= item_op_in;
      item_kind_ff     <= item_kind_in;
      item_weight_ff   <= item_weight_in;
      item_later_ff    <= item_later_in;
      item_payload_ff  <= item_payload_in;
      item_deadline_ff <= item_deadline_in;
      item_time_ff     <= item_time_in;
      rd_idx_ff        <= rd_idx_in;
      s1_idx_ff        <= s1_idx_in;
      s1_live_ff       <= s1_live_in;
      s1_key_ff        <= s1_key_in;
      s1_age_ff        <= s1_age_in;
      s1_payload_ff    <= s1_payload_in;
      best_idx_ff      <= best_idx_in;
      best_key_ff      <= best_key_in;
      best_age_ff      <= best_age_in;
      best_payload_ff  <= best_payload_in;
      free_idx_ff      <= free_idx_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_payload_ff   <= rsp_payload_in;
   end

   // time advances once per item
   a_time_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> time_now_ff == $past(time_now_ff) + 1'b1)
      else $error("time step lost");

   // no table write while the scan reads it
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !wr_en)
      else $error("table written during scan");

   // an extract always answers once its commit is free to go
   a_extract_answers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT && item_op_ff == OP_EXTRACT && out_free
      |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("extract gave no response");

   // a stored entry needs a free slot found by the scan
   a_insert_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT && wr_en && item_op_ff == OP_INSERT
      |-> free_found_ff && wr_addr == free_idx_ff)
      else $error("insert without free slot");

   // the pipeline is empty whenever a new item may enter
   a_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rd_valid_ff && !s1_valid_ff)
      else $error("scan pipeline busy while ready");

endmodule

`default_nettype wire
